### rtl/core/assert_macros.svh
// assertion helpers used by rsp_dp
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/rsp_pkg.sv
`default_nettype none
package rsp_pkg;
    typedef enum logic [4:0] {
        PH_IDLE, PH_SIMPLE, PH_ETYPE_FIRST, PH_ETYPE, PH_ESPACE, PH_EMSG,
        PH_INT_SIGN, PH_INT_FIRST, PH_INT_DIG, PH_BULK_FIRST, PH_BULK_DIG,
        PH_BULK_HLF, PH_BULK_DATA, PH_BULK_CR, PH_ARR_FIRST, PH_ARR_DIG,
        PH_NULL_ONE, PH_NULL_CR, PH_NULL_LF, PH_LF, PH_POP_CHK
    } t_phase;

    typedef enum logic [2:0] {
        NUM_ZERO, NUM_LEN, NUM_INT, NUM_ACC, NUM_NEG1
    } t_num_sel;

    localparam logic [2:0] EV_DATA = 3'd0;
    localparam logic [2:0] EV_END  = 3'd1;
    localparam logic [2:0] EV_INT  = 3'd2;
    localparam logic [2:0] EV_ARR  = 3'd3;
    localparam logic [2:0] EV_NULL = 3'd4;
    localparam logic [2:0] EV_ERR  = 3'd5;

    localparam logic [2:0] KIND_SIMPLE = 3'd0;
    localparam logic [2:0] KIND_BULK   = 3'd1;
    localparam logic [2:0] KIND_ERRSTR = 3'd2;
    localparam logic [2:0] KIND_INT    = 3'd3;
    localparam logic [2:0] KIND_ARRAY  = 3'd4;

    localparam logic [3:0] ERR_NONE     = 4'd0;
    localparam logic [3:0] ERR_TYPE     = 4'd1;
    localparam logic [3:0] ERR_NO_CR    = 4'd2;
    localparam logic [3:0] ERR_NO_LF    = 4'd3;
    localparam logic [3:0] ERR_NULL     = 4'd4;
    localparam logic [3:0] ERR_NO_DIG   = 4'd5;
    localparam logic [3:0] ERR_ETYPE    = 4'd6;
    localparam logic [3:0] ERR_ESPACE   = 4'd7;
    localparam logic [3:0] ERR_ESPACE2  = 4'd8;
    localparam logic [3:0] ERR_EMSG     = 4'd9;
    localparam logic [3:0] ERR_DEEP     = 4'd10;
    localparam logic [3:0] ERR_OVERFLOW = 4'd11;
    localparam logic [3:0] ERR_ZERO     = 4'd12;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOLL  = 8'h24;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int ACC_W = 33;
    localparam int SUM_W = 37;
    localparam logic [SUM_W-1:0] INT_POS_MAX = 37'd2147483647;
    localparam logic [SUM_W-1:0] INT_NEG_MAX = 37'd2147483648;

    typedef struct packed {
        logic       clr;
        logic       kind_we;
        logic [2:0] kind;
        logic       neg_we;
        logic       neg_val;
        logic       acc_add;
        logic       slen_inc;
        logic       brem_load;
        logic       brem_dec;
        logic       push;
        logic       sp_clr;
        logic       sp_dec;
        logic       top_wb;
        logic       out_load;
        logic       out_set;
        logic       out_done;
        logic [2:0] ev;
        logic [7:0] data_byte;
        t_num_sel   num_sel;
        logic [3:0] err;
    } t_cmd;

    typedef struct packed {
        logic       is_digit;
        logic       int_ok;
        logic       len_ok;
        logic       slen_full;
        logic       brem_one;
        logic       acc_zero;
        logic       sp_zero;
        logic       sp_full;
        logic       sp_one;
        logic       top_one;
        logic       out_busy;
        logic [2:0] kind;
    } t_stat;
endpackage
`default_nettype wire

### rtl/core/rsp_in_if.sv
`default_nettype none
interface rsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

### rtl/core/rsp_out_if.sv
`default_nettype none
interface rsp_out_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  event_res;
    logic        [2:0]  kind;
    logic        [7:0]  data_byte;
    logic signed [31:0] number;
    logic        [3:0]  nest_depth;
    logic               message_done;
    logic        [3:0]  error_code;

    modport source (output valid, output event_res, output kind, output data_byte,
                    output number, output nest_depth, output message_done,
                    output error_code, input ready);
    modport sink (input valid, input event_res, input kind, input data_byte,
                  input number, input nest_depth, input message_done,
                  input error_code, output ready);
endinterface
`default_nettype wire

### rtl/core/resp_stream_parser.sv
// a word that produces a result shows it in the cycle after it is accepted
// closing an item inside arrays holds its result while the count stack is popped for each array level it
// completes, and the enclosing level is decremented unless the whole message completes
// throughput: one word per cycle, but input stalls while a result waits to be taken or the stack is popped
// the count stack is popped one level per cycle through its registered read port
// synchronous active-low reset returns the parser to idle with an empty stack
`default_nettype none
module resp_stream_parser #(
    parameter int MAX_DEPTH   = 8,
    parameter int LENGTH_BITS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rsp_in_if.sink    i_in,
    rsp_out_if.source o_out
);
    rsp_pkg::t_cmd  w_cmd;
    rsp_pkg::t_stat w_stat;
    logic           w_ready;
    logic           w_fire;

    assign i_in.ready = w_ready;
    assign w_fire     = i_in.valid && w_ready;

    rsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_byte     (i_in.in_byte),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (w_ready)
    );

    rsp_dp #(
        .MAX_DEPTH   (MAX_DEPTH),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_in.in_byte),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_out   (o_out)
    );
endmodule
`default_nettype wire

### rtl/core/rsp_ctrl.sv
`default_nettype none
module rsp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic [7:0]    i_byte,
    input  wire rsp_pkg::t_stat i_stat,
    output rsp_pkg::t_cmd      o_cmd,
    output logic               o_in_ready
);
    rsp_pkg::t_phase r_phase;
    rsp_pkg::t_phase n_phase;
    logic            w_fail;
    logic [3:0]      w_err;
    logic            w_cr;
    logic            w_lf;
    logic            w_sp;
    logic            w_sign;
    logic            w_text_end;
    logic            w_finish;

    assign w_cr   = (i_byte == rsp_pkg::CH_CR);
    assign w_lf   = (i_byte == rsp_pkg::CH_LF);
    assign w_sp   = (i_byte == rsp_pkg::CH_SP);
    assign w_sign = (i_byte == rsp_pkg::CH_PLUS) || (i_byte == rsp_pkg::CH_MINUS);
    assign w_text_end = !(i_stat.kind == rsp_pkg::KIND_ARRAY) || i_stat.acc_zero;
    assign w_finish   = w_text_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rsp_pkg::PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    // fault decode for the current word
    always_comb begin
        w_fail = 1'b0;
        w_err  = rsp_pkg::ERR_NONE;
        if (i_byte == rsp_pkg::CH_NUL) begin
            w_fail = 1'b1;
            w_err  = rsp_pkg::ERR_ZERO;
        end else begin
            unique case (r_phase)
                rsp_pkg::PH_IDLE: begin
                    if (!(i_byte == rsp_pkg::CH_PLUS || i_byte == rsp_pkg::CH_MINUS ||
                          i_byte == rsp_pkg::CH_DOLL || i_byte == rsp_pkg::CH_COLON ||
                          i_byte == rsp_pkg::CH_STAR)) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_TYPE;
                    end
                end
                rsp_pkg::PH_SIMPLE, rsp_pkg::PH_EMSG: begin
                    if (w_lf) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_NO_CR;
                    end else if (!w_cr && i_stat.slen_full) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_OVERFLOW;
                    end
                end
                rsp_pkg::PH_ETYPE_FIRST: begin
                    if (w_sp || w_cr || w_lf) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_ETYPE;
                    end else if (i_stat.slen_full) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_OVERFLOW;
                    end
                end
                rsp_pkg::PH_ETYPE: begin
                    if (w_cr || w_lf) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_ESPACE;
                    end else if (i_stat.slen_full) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_OVERFLOW;
                    end
                end
                rsp_pkg::PH_ESPACE: begin
                    if (w_sp) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_ESPACE2;
                    end else if (w_cr || w_lf) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_EMSG;
                    end else if (i_stat.slen_full) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_OVERFLOW;
                    end
                end
                rsp_pkg::PH_INT_SIGN, rsp_pkg::PH_INT_FIRST: begin
                    if (r_phase == rsp_pkg::PH_INT_SIGN && w_sign) begin
                        w_fail = 1'b0;
                    end else if (!i_stat.is_digit) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_NO_DIG;
                    end else if (!i_stat.int_ok) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_OVERFLOW;
                    end
                end
                rsp_pkg::PH_INT_DIG: begin
                    if (w_cr) begin
                        w_fail = 1'b0;
                    end else if (!i_stat.is_digit) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_NO_CR;
                    end else if (!i_stat.int_ok) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_OVERFLOW;
                    end
                end
                rsp_pkg::PH_BULK_FIRST, rsp_pkg::PH_ARR_FIRST: begin
                    if (i_byte == rsp_pkg::CH_MINUS) begin
                        w_fail = 1'b0;
                    end else if (!i_stat.is_digit) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_NO_DIG;
                    end else if (!i_stat.len_ok) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_OVERFLOW;
                    end
                end
                rsp_pkg::PH_BULK_DIG, rsp_pkg::PH_ARR_DIG: begin
                    if (w_cr) begin
                        w_fail = 1'b0;
                    end else if (!i_stat.is_digit) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_NO_CR;
                    end else if (!i_stat.len_ok) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_OVERFLOW;
                    end
                end
                rsp_pkg::PH_BULK_HLF, rsp_pkg::PH_NULL_LF: begin
                    if (!w_lf) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_NO_LF;
                    end
                end
                rsp_pkg::PH_BULK_DATA: begin
                    if (i_stat.slen_full) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_OVERFLOW;
                    end
                end
                rsp_pkg::PH_BULK_CR, rsp_pkg::PH_NULL_CR: begin
                    if (!w_cr) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_NO_CR;
                    end
                end
                rsp_pkg::PH_NULL_ONE: begin
                    if (i_byte != rsp_pkg::CH_ONE) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_NULL;
                    end
                end
                rsp_pkg::PH_LF: begin
                    if (!w_lf) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_NO_LF;
                    end else if (!w_finish && i_stat.sp_full) begin
                        w_fail = 1'b1;
                        w_err  = rsp_pkg::ERR_DEEP;
                    end
                end
                default: begin
                    w_fail = 1'b0;
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        if (r_phase == rsp_pkg::PH_POP_CHK) begin
            if (!i_stat.top_one || i_stat.sp_one) begin
                n_phase = rsp_pkg::PH_IDLE;
            end
        end else if (i_fire) begin
            if (w_fail) begin
                n_phase = rsp_pkg::PH_IDLE;
            end else begin
                unique case (r_phase)
                    rsp_pkg::PH_IDLE: begin
                        unique case (i_byte)
                            rsp_pkg::CH_PLUS:  n_phase = rsp_pkg::PH_SIMPLE;
                            rsp_pkg::CH_MINUS: n_phase = rsp_pkg::PH_ETYPE_FIRST;
                            rsp_pkg::CH_DOLL:  n_phase = rsp_pkg::PH_BULK_FIRST;
                            rsp_pkg::CH_COLON: n_phase = rsp_pkg::PH_INT_SIGN;
                            default:           n_phase = rsp_pkg::PH_ARR_FIRST;
                        endcase
                    end
                    rsp_pkg::PH_SIMPLE, rsp_pkg::PH_EMSG: begin
                        if (w_cr) begin
                            n_phase = rsp_pkg::PH_LF;
                        end
                    end
                    rsp_pkg::PH_ETYPE_FIRST: n_phase = rsp_pkg::PH_ETYPE;
                    rsp_pkg::PH_ETYPE: begin
                        if (w_sp) begin
                            n_phase = rsp_pkg::PH_ESPACE;
                        end
                    end
                    rsp_pkg::PH_ESPACE: n_phase = rsp_pkg::PH_EMSG;
                    rsp_pkg::PH_INT_SIGN: begin
                        n_phase = w_sign ? rsp_pkg::PH_INT_FIRST : rsp_pkg::PH_INT_DIG;
                    end
                    rsp_pkg::PH_INT_FIRST: n_phase = rsp_pkg::PH_INT_DIG;
                    rsp_pkg::PH_INT_DIG, rsp_pkg::PH_ARR_DIG: begin
                        if (w_cr) begin
                            n_phase = rsp_pkg::PH_LF;
                        end
                    end
                    rsp_pkg::PH_BULK_FIRST: begin
                        n_phase = (i_byte == rsp_pkg::CH_MINUS) ? rsp_pkg::PH_NULL_ONE
                                                                 : rsp_pkg::PH_BULK_DIG;
                    end
                    rsp_pkg::PH_ARR_FIRST: begin
                        n_phase = (i_byte == rsp_pkg::CH_MINUS) ? rsp_pkg::PH_NULL_ONE
                                                                 : rsp_pkg::PH_ARR_DIG;
                    end
                    rsp_pkg::PH_BULK_DIG: begin
                        if (w_cr) begin
                            n_phase = rsp_pkg::PH_BULK_HLF;
                        end
                    end
                    rsp_pkg::PH_BULK_HLF: begin
                        n_phase = i_stat.acc_zero ? rsp_pkg::PH_BULK_CR : rsp_pkg::PH_BULK_DATA;
                    end
                    rsp_pkg::PH_BULK_DATA: begin
                        if (i_stat.brem_one) begin
                            n_phase = rsp_pkg::PH_BULK_CR;
                        end
                    end
                    rsp_pkg::PH_BULK_CR: n_phase = rsp_pkg::PH_LF;
                    rsp_pkg::PH_NULL_ONE: n_phase = rsp_pkg::PH_NULL_CR;
                    rsp_pkg::PH_NULL_CR: n_phase = rsp_pkg::PH_NULL_LF;
                    rsp_pkg::PH_NULL_LF: begin
                        n_phase = i_stat.sp_zero ? rsp_pkg::PH_IDLE : rsp_pkg::PH_POP_CHK;
                    end
                    rsp_pkg::PH_LF: begin
                        n_phase = (w_finish && !i_stat.sp_zero) ? rsp_pkg::PH_POP_CHK
                                                                : rsp_pkg::PH_IDLE;
                    end
                    default: n_phase = rsp_pkg::PH_IDLE;
                endcase
            end
        end
    end

    // commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.num_sel = rsp_pkg::NUM_ZERO;
        o_in_ready    = (r_phase != rsp_pkg::PH_POP_CHK) && !i_stat.out_busy;
        if (r_phase == rsp_pkg::PH_POP_CHK) begin
            if (!i_stat.top_one) begin
                o_cmd.top_wb  = 1'b1;
                o_cmd.out_set = 1'b1;
            end else begin
                o_cmd.sp_dec = 1'b1;
                if (i_stat.sp_one) begin
                    o_cmd.out_set  = 1'b1;
                    o_cmd.out_done = 1'b1;
                end
            end
        end else if (i_fire) begin
            if (w_fail) begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_set  = 1'b1;
                o_cmd.ev       = rsp_pkg::EV_ERR;
                o_cmd.err      = w_err;
                o_cmd.sp_clr   = 1'b1;
                if (w_err == rsp_pkg::ERR_TYPE) begin
                    o_cmd.kind_we = 1'b1;
                    o_cmd.kind    = rsp_pkg::KIND_SIMPLE;
                end
            end else begin
                unique case (r_phase)
                    rsp_pkg::PH_IDLE: begin
                        o_cmd.clr     = 1'b1;
                        o_cmd.kind_we = 1'b1;
                        unique case (i_byte)
                            rsp_pkg::CH_PLUS:  o_cmd.kind = rsp_pkg::KIND_SIMPLE;
                            rsp_pkg::CH_MINUS: o_cmd.kind = rsp_pkg::KIND_ERRSTR;
                            rsp_pkg::CH_DOLL:  o_cmd.kind = rsp_pkg::KIND_BULK;
                            rsp_pkg::CH_COLON: o_cmd.kind = rsp_pkg::KIND_INT;
                            default:           o_cmd.kind = rsp_pkg::KIND_ARRAY;
                        endcase
                    end
                    rsp_pkg::PH_SIMPLE, rsp_pkg::PH_EMSG, rsp_pkg::PH_ETYPE_FIRST,
                    rsp_pkg::PH_ETYPE, rsp_pkg::PH_ESPACE, rsp_pkg::PH_BULK_DATA: begin
                        if (!w_cr || r_phase == rsp_pkg::PH_BULK_DATA ||
                            r_phase == rsp_pkg::PH_ETYPE_FIRST ||
                            r_phase == rsp_pkg::PH_ESPACE) begin
                            o_cmd.slen_inc  = 1'b1;
                            o_cmd.out_load  = 1'b1;
                            o_cmd.out_set   = 1'b1;
                            o_cmd.ev        = rsp_pkg::EV_DATA;
                            o_cmd.data_byte = i_byte;
                            o_cmd.brem_dec  = (r_phase == rsp_pkg::PH_BULK_DATA);
                        end
                    end
                    rsp_pkg::PH_INT_SIGN, rsp_pkg::PH_INT_FIRST, rsp_pkg::PH_INT_DIG,
                    rsp_pkg::PH_BULK_FIRST, rsp_pkg::PH_ARR_FIRST,
                    rsp_pkg::PH_BULK_DIG, rsp_pkg::PH_ARR_DIG: begin
                        if (r_phase == rsp_pkg::PH_INT_SIGN && w_sign) begin
                            o_cmd.neg_we  = 1'b1;
                            o_cmd.neg_val = (i_byte == rsp_pkg::CH_MINUS);
                        end else if (i_stat.is_digit) begin
                            o_cmd.acc_add = 1'b1;
                        end
                    end
                    rsp_pkg::PH_BULK_HLF: o_cmd.brem_load = 1'b1;
                    rsp_pkg::PH_NULL_LF: begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.ev       = rsp_pkg::EV_NULL;
                        o_cmd.num_sel  = rsp_pkg::NUM_NEG1;
                        o_cmd.out_set  = i_stat.sp_zero;
                        o_cmd.out_done = i_stat.sp_zero;
                    end
                    rsp_pkg::PH_LF: begin
                        o_cmd.out_load = 1'b1;
                        if (i_stat.kind == rsp_pkg::KIND_INT) begin
                            o_cmd.ev      = rsp_pkg::EV_INT;
                            o_cmd.num_sel = rsp_pkg::NUM_INT;
                        end else if (i_stat.kind == rsp_pkg::KIND_ARRAY) begin
                            o_cmd.ev      = rsp_pkg::EV_ARR;
                            o_cmd.num_sel = rsp_pkg::NUM_ACC;
                        end else begin
                            o_cmd.ev      = rsp_pkg::EV_END;
                            o_cmd.num_sel = rsp_pkg::NUM_LEN;
                        end
                        if (w_finish) begin
                            o_cmd.out_set  = i_stat.sp_zero;
                            o_cmd.out_done = i_stat.sp_zero;
                        end else begin
                            o_cmd.out_set = 1'b1;
                            o_cmd.push    = 1'b1;
                        end
                    end
                    default: o_cmd.clr = 1'b0;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

### rtl/core/rsp_dp.sv
`default_nettype none
`include "assert_macros.svh"
module rsp_dp #(
    parameter int MAX_DEPTH   = 8,
    parameter int LENGTH_BITS = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [7:0]     i_byte,
    input  wire rsp_pkg::t_cmd  i_cmd,
    output rsp_pkg::t_stat      o_stat,
    rsp_out_if.source           o_out
);
    localparam int AW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int SPW = $clog2(MAX_DEPTH + 1);
    localparam int SW  = rsp_pkg::SUM_W;
    localparam logic [SW-1:0] LEN_MAX = (SW'(1) << (LENGTH_BITS - 1)) - SW'(1);

    logic [rsp_pkg::ACC_W-1:0] r_acc;
    logic                      r_neg;
    logic [2:0]                r_kind;
    logic [LENGTH_BITS-1:0]    r_brem;
    logic [LENGTH_BITS-1:0]    r_slen;
    logic [SPW-1:0]            r_sp;
    logic [SPW-1:0]            n_sp;
    logic [SPW-1:0]            w_rd_ptr;
    logic [SPW-1:0]            w_top_ptr;
    logic [LENGTH_BITS-1:0]    r_top;
    logic [LENGTH_BITS-1:0]    r_stack [2**AW];

    logic                      r_valid;
    logic [2:0]                r_event;
    logic [2:0]                r_okind;
    logic [7:0]                r_obyte;
    logic [31:0]               r_num;
    logic [3:0]                r_depth;
    logic                      r_done;
    logic [3:0]                r_err;

    logic [7:0]                w_dig;
    logic [SW-1:0]             w_sum;
    logic [SW-1:0]             w_ilim;
    logic [31:0]               w_num;
    logic [2:0]                w_kind;

    assign w_dig  = i_byte - rsp_pkg::CH_ZERO;
    assign w_sum  = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + SW'(w_dig[3:0]);
    assign w_ilim = r_neg ? rsp_pkg::INT_NEG_MAX : rsp_pkg::INT_POS_MAX;
    assign w_kind = i_cmd.kind_we ? i_cmd.kind : r_kind;

    always_comb begin
        case (i_cmd.num_sel)
            rsp_pkg::NUM_LEN:  w_num = 32'(r_slen);
            rsp_pkg::NUM_INT:  w_num = r_neg ? (32'd0 - r_acc[31:0]) : r_acc[31:0];
            rsp_pkg::NUM_ACC:  w_num = r_acc[31:0];
            rsp_pkg::NUM_NEG1: w_num = '1;
            default:           w_num = '0;
        endcase
    end

    always_comb begin
        n_sp = r_sp;
        if (i_cmd.sp_clr) begin
            n_sp = '0;
        end else if (i_cmd.push) begin
            n_sp = r_sp + SPW'(1);
        end else if (i_cmd.sp_dec) begin
            n_sp = r_sp - SPW'(1);
        end
    end

    assign w_rd_ptr  = n_sp - SPW'(1);
    assign w_top_ptr = r_sp - SPW'(1);

    always_comb begin
        o_stat           = '0;
        o_stat.is_digit  = (i_byte >= rsp_pkg::CH_ZERO) && (i_byte <= rsp_pkg::CH_NINE);
        o_stat.int_ok    = (w_sum <= w_ilim);
        o_stat.len_ok    = (w_sum <= LEN_MAX);
        o_stat.slen_full = (SW'(r_slen) >= LEN_MAX);
        o_stat.brem_one  = (r_brem == LENGTH_BITS'(1));
        o_stat.acc_zero  = (r_acc == '0);
        o_stat.sp_zero   = (r_sp == '0);
        o_stat.sp_full   = (r_sp >= SPW'(MAX_DEPTH));
        o_stat.sp_one    = (r_sp == SPW'(1));
        o_stat.top_one   = (r_top == LENGTH_BITS'(1));
        o_stat.out_busy  = r_valid;
        o_stat.kind      = r_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_neg  <= 1'b0;
            r_kind <= '0;
            r_brem <= '0;
            r_slen <= '0;
            r_sp   <= '0;
        end else begin
            r_sp <= n_sp;
            if (i_cmd.kind_we) begin
                r_kind <= i_cmd.kind;
            end
            if (i_cmd.clr) begin
                r_acc  <= '0;
                r_neg  <= 1'b0;
                r_brem <= '0;
                r_slen <= '0;
            end else begin
                if (i_cmd.neg_we) begin
                    r_neg <= i_cmd.neg_val;
                end
                if (i_cmd.acc_add) begin
                    r_acc <= w_sum[rsp_pkg::ACC_W-1:0];
                end
                if (i_cmd.slen_inc) begin
                    r_slen <= r_slen + LENGTH_BITS'(1);
                end
                if (i_cmd.brem_load) begin
                    r_brem <= r_acc[LENGTH_BITS-1:0];
                end else if (i_cmd.brem_dec) begin
                    r_brem <= r_brem - LENGTH_BITS'(1);
                end
            end
        end
    end

    // stack of remaining element counts
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack[r_sp[AW-1:0]] <= r_acc[LENGTH_BITS-1:0];
        end else if (i_cmd.top_wb) begin
            r_stack[w_top_ptr[AW-1:0]] <= r_top - LENGTH_BITS'(1);
        end
        r_top <= r_stack[w_rd_ptr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_set) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_event <= i_cmd.ev;
            r_okind <= w_kind;
            r_obyte <= i_cmd.data_byte;
            r_num   <= w_num;
            r_depth <= 4'(r_sp);
            r_err   <= i_cmd.err;
        end
        if (i_cmd.out_set) begin
            r_done <= i_cmd.out_done;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.event_res    = r_event;
    assign o_out.kind         = r_okind;
    assign o_out.data_byte    = r_obyte;
    assign o_out.number       = r_num;
    assign o_out.nest_depth   = r_depth;
    assign o_out.message_done = r_done;
    assign o_out.error_code   = r_err;

    `RSP_ASSERT_IMP(a_push_room, i_clk, i_rst_n, i_cmd.push, r_sp < SPW'(MAX_DEPTH))
    `RSP_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_cmd.sp_dec || i_cmd.top_wb, r_sp != '0)
    `RSP_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, i_cmd.out_set, !r_valid)
    `RSP_ASSERT_NXT(a_push_depth, i_clk, i_rst_n, i_cmd.push && !i_cmd.sp_clr,
                    r_sp != '0 && r_valid)
endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    typedef struct packed {
        logic [2:0]  ev;
        logic [2:0]  kind;
        logic [7:0]  db;
        logic [31:0] num;
        logic [3:0]  depth;
        logic        done;
        logic [3:0]  err;
    } t_resp_word;

    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        t_resp_word exp;
    } t_row;

    localparam int           NEST_MAX    = 8;
    localparam longint       LEN_LIMIT   = 64'd2147483647;
    localparam int           TARGET_BYTES = 600;
    localparam int           CYCLE_LIMIT = 500000;

    logic clk;
    logic rst_n;
    rsp_in_if  in_ch ();
    rsp_out_if out_ch ();

    resp_stream_parser DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // parser state mirror
    rsp_pkg::t_phase ph;
    logic [2:0]      cur_kind;
    bit              neg;
    longint unsigned acc;
    int unsigned     brem;
    int unsigned     slen;
    int unsigned     counts [NEST_MAX];
    int              sp;

    t_resp_word event_q[$];
    logic [7:0] stream_q[$];
    t_row       dir_q[$];
    int         errors;
    int         cycles;
    int         sent;
    bit         calm;

    function automatic t_resp_word make_word(logic [2:0] ev, logic [7:0] b,
                                             logic [31:0] n, logic [3:0] e);
        t_resp_word w;
        w.ev = ev;
        w.kind = cur_kind;
        w.db = b;
        w.num = n;
        w.depth = sp[3:0];
        w.done = 1'b0;
        w.err = e;
        return w;
    endfunction

    function automatic string word_str(t_resp_word w);
        return $sformatf("ev %0d kind %0d byte %h num %0d depth %0d done %0d err %0d",
                         w.ev, w.kind, w.db, $signed(w.num), w.depth, w.done, w.err);
    endfunction

    function automatic bit close_item();
        ph = rsp_pkg::PH_IDLE;
        while (sp > 0) begin
            counts[sp-1]--;
            if (counts[sp-1] != 0) return 1'b0;
            sp--;
        end
        return 1'b1;
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= rsp_pkg::CH_ZERO && c <= rsp_pkg::CH_NINE;
    endfunction

    function automatic void parse_byte(input logic [7:0] c, output bit has,
                                       output t_resp_word w);
        bit bad;
        logic [3:0] code;
        bit arr;
        longint unsigned lim;
        longint unsigned nv;
        logic [31:0] v;
        has = 0;
        bad = 0;
        code = rsp_pkg::ERR_NONE;
        w = '0;
        if (c == rsp_pkg::CH_NUL) begin
            bad = 1;
            code = rsp_pkg::ERR_ZERO;
        end else begin
            case (ph)
                rsp_pkg::PH_IDLE: begin
                    acc = 0; neg = 0; slen = 0; brem = 0;
                    if (c == rsp_pkg::CH_PLUS) begin
                        cur_kind = rsp_pkg::KIND_SIMPLE; ph = rsp_pkg::PH_SIMPLE;
                    end else if (c == rsp_pkg::CH_MINUS) begin
                        cur_kind = rsp_pkg::KIND_ERRSTR; ph = rsp_pkg::PH_ETYPE_FIRST;
                    end else if (c == rsp_pkg::CH_DOLL) begin
                        cur_kind = rsp_pkg::KIND_BULK; ph = rsp_pkg::PH_BULK_FIRST;
                    end else if (c == rsp_pkg::CH_COLON) begin
                        cur_kind = rsp_pkg::KIND_INT; ph = rsp_pkg::PH_INT_SIGN;
                    end else if (c == rsp_pkg::CH_STAR) begin
                        cur_kind = rsp_pkg::KIND_ARRAY; ph = rsp_pkg::PH_ARR_FIRST;
                    end else begin
                        cur_kind = rsp_pkg::KIND_SIMPLE; bad = 1; code = rsp_pkg::ERR_TYPE;
                    end
                end
                rsp_pkg::PH_SIMPLE, rsp_pkg::PH_EMSG, rsp_pkg::PH_ETYPE_FIRST,
                rsp_pkg::PH_ETYPE, rsp_pkg::PH_ESPACE, rsp_pkg::PH_BULK_DATA: begin
                    if ((ph == rsp_pkg::PH_SIMPLE || ph == rsp_pkg::PH_EMSG)
                        && c == rsp_pkg::CH_CR) ph = rsp_pkg::PH_LF;
                    else if ((ph == rsp_pkg::PH_SIMPLE || ph == rsp_pkg::PH_EMSG)
                             && c == rsp_pkg::CH_LF) begin
                        bad = 1; code = rsp_pkg::ERR_NO_CR;
                    end else if (ph == rsp_pkg::PH_ETYPE_FIRST
                                 && (c == rsp_pkg::CH_SP || c == rsp_pkg::CH_CR
                                     || c == rsp_pkg::CH_LF)) begin
                        bad = 1; code = rsp_pkg::ERR_ETYPE;
                    end else if (ph == rsp_pkg::PH_ETYPE
                                 && (c == rsp_pkg::CH_CR || c == rsp_pkg::CH_LF)) begin
                        bad = 1; code = rsp_pkg::ERR_ESPACE;
                    end else if (ph == rsp_pkg::PH_ESPACE && c == rsp_pkg::CH_SP) begin
                        bad = 1; code = rsp_pkg::ERR_ESPACE2;
                    end else if (ph == rsp_pkg::PH_ESPACE
                                 && (c == rsp_pkg::CH_CR || c == rsp_pkg::CH_LF)) begin
                        bad = 1; code = rsp_pkg::ERR_EMSG;
                    end else begin
                        if (ph == rsp_pkg::PH_ETYPE_FIRST) ph = rsp_pkg::PH_ETYPE;
                        else if (ph == rsp_pkg::PH_ETYPE && c == rsp_pkg::CH_SP)
                            ph = rsp_pkg::PH_ESPACE;
                        else if (ph == rsp_pkg::PH_ESPACE) ph = rsp_pkg::PH_EMSG;
                        else if (ph == rsp_pkg::PH_BULK_DATA) begin
                            brem--;
                            if (brem == 0) ph = rsp_pkg::PH_BULK_CR;
                        end
                        if (slen >= LEN_LIMIT) begin
                            bad = 1; code = rsp_pkg::ERR_OVERFLOW;
                        end else begin
                            slen++;
                            w = make_word(rsp_pkg::EV_DATA, c, 32'd0, rsp_pkg::ERR_NONE);
                            has = 1;
                        end
                    end
                end
                rsp_pkg::PH_INT_SIGN, rsp_pkg::PH_INT_FIRST, rsp_pkg::PH_INT_DIG: begin
                    if (ph == rsp_pkg::PH_INT_SIGN
                        && (c == rsp_pkg::CH_MINUS || c == rsp_pkg::CH_PLUS)) begin
                        neg = (c == rsp_pkg::CH_MINUS);
                        ph = rsp_pkg::PH_INT_FIRST;
                    end else if (ph != rsp_pkg::PH_INT_DIG && !is_num(c)) begin
                        bad = 1; code = rsp_pkg::ERR_NO_DIG;
                    end else begin
                        ph = rsp_pkg::PH_INT_DIG;
                        if (c == rsp_pkg::CH_CR) ph = rsp_pkg::PH_LF;
                        else if (!is_num(c)) begin bad = 1; code = rsp_pkg::ERR_NO_CR; end
                        else begin
                            lim = neg ? 64'd2147483648 : 64'd2147483647;
                            nv = acc * 10 + (c - rsp_pkg::CH_ZERO);
                            if (nv > lim) begin bad = 1; code = rsp_pkg::ERR_OVERFLOW; end
                            else acc = nv;
                        end
                    end
                end
                rsp_pkg::PH_BULK_FIRST, rsp_pkg::PH_ARR_FIRST, rsp_pkg::PH_BULK_DIG,
                rsp_pkg::PH_ARR_DIG: begin
                    arr = (ph == rsp_pkg::PH_ARR_FIRST || ph == rsp_pkg::PH_ARR_DIG);
                    if ((ph == rsp_pkg::PH_BULK_FIRST || ph == rsp_pkg::PH_ARR_FIRST)
                        && c == rsp_pkg::CH_MINUS)
                        ph = rsp_pkg::PH_NULL_ONE;
                    else if ((ph == rsp_pkg::PH_BULK_FIRST || ph == rsp_pkg::PH_ARR_FIRST)
                             && !is_num(c)) begin
                        bad = 1; code = rsp_pkg::ERR_NO_DIG;
                    end else begin
                        ph = arr ? rsp_pkg::PH_ARR_DIG : rsp_pkg::PH_BULK_DIG;
                        if (c == rsp_pkg::CH_CR) ph = arr ? rsp_pkg::PH_LF : rsp_pkg::PH_BULK_HLF;
                        else if (!is_num(c)) begin bad = 1; code = rsp_pkg::ERR_NO_CR; end
                        else begin
                            nv = acc * 10 + (c - rsp_pkg::CH_ZERO);
                            if (nv > LEN_LIMIT) begin
                                bad = 1; code = rsp_pkg::ERR_OVERFLOW;
                            end else acc = nv;
                        end
                    end
                end
                rsp_pkg::PH_BULK_HLF: begin
                    if (c != rsp_pkg::CH_LF) begin bad = 1; code = rsp_pkg::ERR_NO_LF; end
                    else begin
                        brem = acc[31:0];
                        ph = (brem != 0) ? rsp_pkg::PH_BULK_DATA : rsp_pkg::PH_BULK_CR;
                    end
                end
                rsp_pkg::PH_BULK_CR: begin
                    if (c != rsp_pkg::CH_CR) begin bad = 1; code = rsp_pkg::ERR_NO_CR; end
                    else ph = rsp_pkg::PH_LF;
                end
                rsp_pkg::PH_NULL_ONE: begin
                    if (c != rsp_pkg::CH_ONE) begin bad = 1; code = rsp_pkg::ERR_NULL; end
                    else ph = rsp_pkg::PH_NULL_CR;
                end
                rsp_pkg::PH_NULL_CR: begin
                    if (c != rsp_pkg::CH_CR) begin bad = 1; code = rsp_pkg::ERR_NO_CR; end
                    else ph = rsp_pkg::PH_NULL_LF;
                end
                rsp_pkg::PH_NULL_LF: begin
                    if (c != rsp_pkg::CH_LF) begin bad = 1; code = rsp_pkg::ERR_NO_LF; end
                    else begin
                        w = make_word(rsp_pkg::EV_NULL, 8'd0, 32'hFFFF_FFFF,
                                      rsp_pkg::ERR_NONE);
                        w.done = close_item();
                        has = 1;
                    end
                end
                rsp_pkg::PH_LF: begin
                    if (c != rsp_pkg::CH_LF) begin bad = 1; code = rsp_pkg::ERR_NO_LF; end
                    else if (cur_kind == rsp_pkg::KIND_INT) begin
                        v = acc[31:0];
                        if (neg) v = -v;
                        w = make_word(rsp_pkg::EV_INT, 8'd0, v, rsp_pkg::ERR_NONE);
                        w.done = close_item();
                        has = 1;
                    end else if (cur_kind == rsp_pkg::KIND_ARRAY) begin
                        if (acc == 0) begin
                            w = make_word(rsp_pkg::EV_ARR, 8'd0, 32'd0, rsp_pkg::ERR_NONE);
                            w.done = close_item();
                            has = 1;
                        end else if (sp >= NEST_MAX) begin
                            bad = 1; code = rsp_pkg::ERR_DEEP;
                        end else begin
                            w = make_word(rsp_pkg::EV_ARR, 8'd0, acc[31:0],
                                          rsp_pkg::ERR_NONE);
                            counts[sp] = acc[31:0];
                            sp++;
                            ph = rsp_pkg::PH_IDLE;
                            has = 1;
                        end
                    end else begin
                        w = make_word(rsp_pkg::EV_END, 8'd0, slen, rsp_pkg::ERR_NONE);
                        w.done = close_item();
                        has = 1;
                    end
                end
                default: begin
                    ph = rsp_pkg::PH_IDLE;
                    sp = 0;
                end
            endcase
        end
        if (bad) begin
            w = make_word(rsp_pkg::EV_ERR, 8'd0, 32'd0, code);
            ph = rsp_pkg::PH_IDLE;
            sp = 0;
            has = 1;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed, input t_resp_word e);
        int gap;
        bit has;
        t_resp_word w;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        do @(posedge clk); while (!in_ch.ready);
        parse_byte(b, has, w);
        if (has) event_q.push_back(typed ? e : w);
        sent++;
        @(negedge clk);
    endtask

    task automatic push_text(input string s);
        foreach (s[i]) stream_q.push_back(s[i]);
    endtask

    task automatic add_text(input string s);
        t_row r;
        r = '0;
        foreach (s[i]) begin
            r.b = s[i];
            dir_q.push_back(r);
        end
    endtask

    task automatic add_typed(input logic [7:0] b, input t_resp_word e);
        t_row r;
        r.b = b;
        r.typed = 1'b1;
        r.exp = e;
        dir_q.push_back(r);
    endtask

    task automatic push_junk(input int n, input bit any_byte);
        repeat (n) stream_q.push_back(any_byte ? 8'($urandom_range(1, 255))
                                               : 8'($urandom_range(8'h41, 8'h7A)));
    endtask

    task automatic gen_item(input int lvl);
        int r;
        int n;
        longint val;
        r = $urandom_range(0, 99);
        if (lvl >= 2 && r >= 66 && $urandom_range(0, 2) != 0) r = $urandom_range(0, 65);
        if (r < 12) begin
            push_text("+");
            push_junk($urandom_range(0, 5), 0);
            push_text("\r\n");
        end else if (r < 24) begin
            push_text("-");
            push_junk($urandom_range(1, 3), 0);
            push_text(" ");
            push_junk($urandom_range(1, 4), 0);
            push_text("\r\n");
        end else if (r < 42) begin
            case ($urandom_range(0, 5))
                0: val = longint'($signed($urandom));
                1: val = 64'sd2147483647;
                2: val = -64'sd2147483648;
                3: val = 64'sd2147483648;
                4: val = -64'sd2147483649;
                default: val = $urandom_range(0, 99);
            endcase
            push_text(":");
            if (val >= 0 && $urandom_range(0, 2) == 0) push_text("+");
            push_text($sformatf("%0d\r\n", val));
        end else if (r < 58) begin
            n = $urandom_range(0, 6);
            push_text($sformatf("$%0d\r\n", n));
            push_junk(n, 1);
            push_text("\r\n");
        end else if (r < 61) begin
            push_text("$99999999999\r\n");
        end else if (r < 66) begin
            push_text($urandom_range(0, 1) ? "$-1\r\n" : "*-1\r\n");
        end else if (r < 70 && lvl == 0) begin
            repeat (NEST_MAX + $urandom_range(0, 1)) push_text("*1\r\n");
            push_text(":7\r\n");
        end else begin
            n = (lvl < 2) ? $urandom_range(0, 3) : $urandom_range(0, 1);
            push_text($sformatf("*%0d\r\n", n));
            repeat (n) gen_item(lvl + 1);
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("resp_stream_parser regression: fail");
            $finish;
        end
    end

    // result checking
    always @(posedge clk) begin
        t_resp_word g;
        t_resp_word x;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            g = '{out_ch.event_res, out_ch.kind, out_ch.data_byte, out_ch.number,
                  out_ch.nest_depth, out_ch.message_done, out_ch.error_code};
            if (event_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected word ev %0d err %0d", $time, g.ev, g.err);
            end else begin
                x = event_q.pop_front();
                if (g !== x) begin
                    errors++;
                    $display("%0t: mismatch exp %s / got %s", $time, word_str(x),
                             word_str(g));
                end
            end
        end
    end

    // sink side stalls
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            gap = calm ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        sent = 0;
        calm = 0;
        in_ch.valid = 1'b0;
        in_ch.in_byte = 8'h00;
        ph = rsp_pkg::PH_IDLE; cur_kind = rsp_pkg::KIND_SIMPLE; neg = 0; acc = 0;
        brem = 0; slen = 0; sp = 0;
        foreach (counts[i]) counts[i] = 0;

        // directed stimulus table
        add_typed(rsp_pkg::CH_NUL, '{rsp_pkg::EV_ERR, rsp_pkg::KIND_SIMPLE, 8'h00, 32'd0,
                                     4'd0, 1'b0, rsp_pkg::ERR_ZERO});
        add_typed(8'hFF, '{rsp_pkg::EV_ERR, rsp_pkg::KIND_SIMPLE, 8'h00, 32'd0,
                           4'd0, 1'b0, rsp_pkg::ERR_TYPE});
        add_text("$-1\r");
        add_typed(rsp_pkg::CH_LF, '{rsp_pkg::EV_NULL, rsp_pkg::KIND_BULK, 8'h00,
                                    32'hFFFF_FFFF, 4'd0, 1'b1, rsp_pkg::ERR_NONE});
        add_text("*0\r");
        add_typed(rsp_pkg::CH_LF, '{rsp_pkg::EV_ARR, rsp_pkg::KIND_ARRAY, 8'h00, 32'd0,
                                    4'd0, 1'b1, rsp_pkg::ERR_NONE});
        add_text(":+5\r\n-A B\r\n");

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_q[i]) send_byte(dir_q[i].b, dir_q[i].typed, dir_q[i].exp);

        // hold off until the parser drains
        in_ch.valid <= 1'b0;
        while (event_q.size() != 0) @(negedge clk);
        repeat (12) @(negedge clk);

        while (sent < TARGET_BYTES) begin
            if ($urandom_range(0, 15) == 0) calm = !calm;
            gen_item(0);
            if ($urandom_range(0, 9) == 0 && stream_q.size() > 0) begin
                if ($urandom_range(0, 1))
                    stream_q[$urandom_range(0, stream_q.size() - 1)] = 8'($urandom_range(0, 255));
                else
                    stream_q.insert($urandom_range(0, stream_q.size() - 1),
                                    8'($urandom_range(0, 255)));
            end
            while (stream_q.size() > 0) send_byte(stream_q.pop_front(), 0, '0);
        end
        in_ch.valid <= 1'b0;

        while (event_q.size() != 0) @(negedge clk);
        repeat (24) @(negedge clk);
        if (errors == 0 && event_q.size() == 0)
            $display("resp_stream_parser regression: pass");
        else
            $display("resp_stream_parser regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
